>>> rtl/oahi_pkg.sv
// ----------------------------------------------------------------------------
// oahi_pkg: shared types and codes for the open-addressing hash insert block.
// Holds the item and result payloads, the kind and status codes, the
// configuration register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package oahi_pkg;

    // Field widths of the payloads and of the configuration port.
    localparam int KEY_W       = 16;
    localparam int KIND_W      = 2;
    localparam int SLOT_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int STATUS_W    = 2;
    localparam int SIZE_W      = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    // Key bits consumed per cycle by the remainder unit.
    localparam int DIGITS_PER_STEP = 4;

    // Reset value of the table size register.
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 7'd64;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROBE_MODE = 1'b1;

    // One input item.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot_index;
    } request_t;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   placed_slot;
        logic [COUNT_W-1:0]  probe_count;
        logic [KEY_W-1:0]    read_key;
        logic                read_used;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                mod_step;
        logic                probe_step;
        logic                read_issue;
        logic                clear_all;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_last;
        logic slot_free;
        logic probe_last;
    } dpath_stat_t;

endpackage

>>> rtl/open_addressing_hash_insert.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_insert: open-addressing hash table insert block.
//
// An item is taken at a rising edge with start high and busy low. Insert
// items hash the key to key mod table_size and probe linearly or
// quadratically (probe_mode) for the first empty slot; clear items empty
// every slot; read items return one slot's key and used flag.
// Each item of a known kind gives one result on result, marked by done for
// exactly one cycle; the receiver cannot hold it off. Unknown kinds give none.
// An insert runs the remainder unit, four key bits a cycle, then probes the
// used bits at the home slot and once more for each used slot met before the
// key is placed, or until it has probed as many slots as the table has, and
// then loads the result register. A read goes through the registered read
// of the key RAM, then the result register; a clear only the result register.
// busy is low again in the cycle that done rises, so items follow back to
// back. The write port (wr_en, wr_index, wr_data) sets table_size and
// probe_mode and is to be used while the block is idle; nothing enforces it.
// Reset empties every slot at once and sets table_size to 64, linear mode.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert import oahi_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  request_t               request,
    output logic                   done,
    output result_t                result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    ctrl_cmd_t   cmd;
    dpath_stat_t stat;

    // Controller.
    oahi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (request.kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath.
    oahi_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .request  (request),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result),
        .done     (done)
    );

    // An accepted insert keeps the block busy for its remainder phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.kind == KIND_INSERT)) |=> busy)
    else $error("insert item accepted without going busy");

    // A result is only shown once the block has finished its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
    else $error("result strobe while an item is still in work");

    // A full table reports a nonzero probe count and no placed slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |->
            (result.placed_slot == '0) && (result.probe_count != '0))
    else $error("table full result with bad fields");

    // Only a read result may report a used slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_READ)) |-> !result.read_used)
    else $error("read_used set on a result that is not a read");

endmodule

>>> rtl/oahi_ram.sv
// ----------------------------------------------------------------------------
// oahi_ram: generic single-write, single-read RAM with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module oahi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/oahi_ctrl.sv
// ----------------------------------------------------------------------------
// oahi_ctrl: controller state machine of the hash insert block.
// Decodes each accepted item and sequences the remainder, probe and read
// phases of the datapath.
// ----------------------------------------------------------------------------
module oahi_ctrl import oahi_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] kind,
    input  dpath_stat_t       stat,
    output ctrl_cmd_t         cmd,
    output logic              busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MOD   = 4'b0010,
        S_PROBE = 4'b0100,
        S_READ  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_INSERT:
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_MOD;
                        end
                        KIND_CLEAR:
                        begin
                            cmd.clear_all   = 1'b1;
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_CLEARED;
                        end
                        KIND_READ:
                        begin
                            cmd.load       = 1'b1;
                            cmd.read_issue = 1'b1;
                            state_next     = S_READ;
                        end
                        default:
                        begin
                            // An unknown kind is dropped without a result.
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_INSERTED;
                    state_next      = S_IDLE;
                end
                else if (stat.probe_last)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_FULL;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_READ;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> rtl/oahi_dpath.sv
// ----------------------------------------------------------------------------
// oahi_dpath: datapath of the hash insert block.
// Holds the configuration registers, the key store, the used bits, the
// remainder unit for the home slot, the probe stepper and the result register.
// ----------------------------------------------------------------------------
module oahi_dpath import oahi_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  request_t               request,
    input  ctrl_cmd_t              cmd,
    output dpath_stat_t            stat,
    output result_t                result,
    output logic                   done
);

    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int SW        = AW + 1;
    localparam int MOD_STEPS = KEY_W / DIGITS_PER_STEP;
    localparam int MCW       = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam logic [SW-1:0]     DEPTH_VAL   = SW'(TABLE_DEPTH);
    localparam logic [SIZE_W-1:0] DEPTH_LIMIT = SIZE_W'(TABLE_DEPTH);

    logic [SIZE_W-1:0]      table_size_reg;
    logic                   probe_mode_reg;
    logic [TABLE_DEPTH-1:0] used_reg;
    logic                   done_reg;
    result_t                result_reg;
    result_t                result_next;

    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  shift_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [MCW-1:0]    mod_cnt_reg;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     step_reg;
    logic [SW-1:0]     count_reg;

    logic [SW-1:0]     eff_size;
    logic [SW-1:0]     rem;
    logic [SW-1:0]     trial;
    logic [AW-1:0]     mod_rem;
    logic [SW-1:0]     pos_sum;
    logic [AW-1:0]     pos_adv;
    logic [SW-1:0]     step_sum;
    logic [AW-1:0]     step_adv;
    logic              idx_in_range;
    logic              rd_used;
    logic              ram_we;
    logic [KEY_W-1:0]  ram_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
            probe_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TABLE_SIZE: table_size_reg <= wr_data[SIZE_W-1:0];
                REG_PROBE_MODE: probe_mode_reg <= wr_data[0];
                default: ;
            endcase
        end
    end

    // Table size in use: zero counts as one, anything above the depth as the depth.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            eff_size = SW'(1);
        end
        else if (table_size_reg > DEPTH_LIMIT)
        begin
            eff_size = DEPTH_VAL;
        end
        else
        begin
            eff_size = table_size_reg[SW-1:0];
        end
    end

    // Remainder unit: DIGITS_PER_STEP restoring steps per cycle, key MSB first.
    always_comb
    begin
        rem = {1'b0, pos_reg};
        for (int i = 0; i < DIGITS_PER_STEP; i++)
        begin
            trial = {rem[AW-1:0], shift_reg[KEY_W-1-i]};
            if (trial >= eff_size)
            begin
                trial = trial - eff_size;
            end
            rem = trial;
        end
        mod_rem = rem[AW-1:0];
    end

    // Probe stepper. The step is 1 in linear mode, and (2j + 1) mod size in
    // quadratic mode, so each probe position follows from the last one.
    always_comb
    begin
        pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};
        if (pos_sum >= eff_size)
        begin
            pos_sum = pos_sum - eff_size;
        end
        pos_adv = pos_sum[AW-1:0];

        step_sum = {1'b0, step_reg} + SW'(2);
        if (step_sum >= eff_size)
        begin
            step_sum = step_sum - eff_size;
        end
        step_adv = step_sum[AW-1:0];
    end

    // Item and probe registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg     <= request.key;
            shift_reg   <= request.key;
            idx_reg     <= request.slot_index;
            mod_cnt_reg <= '0;
            pos_reg     <= '0;
            step_reg    <= AW'(1);
            count_reg   <= '0;
        end
        else if (cmd.mod_step)
        begin
            shift_reg   <= shift_reg << DIGITS_PER_STEP;
            mod_cnt_reg <= mod_cnt_reg + MCW'(1);
            pos_reg     <= mod_rem;
        end
        else if (cmd.probe_step)
        begin
            pos_reg   <= pos_adv;
            count_reg <= count_reg + SW'(1);
            if (probe_mode_reg)
            begin
                step_reg <= step_adv;
            end
        end
    end

    // Used bits: cleared at reset and by a clear item, set by an insert.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            used_reg <= '0;
        end
        else if (ram_we)
        begin
            used_reg[pos_reg] <= 1'b1;
        end
    end

    // Key store.
    assign ram_we = cmd.emit && (cmd.emit_status == ST_INSERTED);

    oahi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (pos_reg),
        .wr_data (key_reg),
        .rd_en   (cmd.read_issue),
        .rd_addr (request.slot_index[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Status to the controller.
    assign stat.mod_last   = (mod_cnt_reg == MCW'(MOD_STEPS - 1));
    assign stat.slot_free  = !used_reg[pos_reg];
    assign stat.probe_last = (count_reg == (eff_size - SW'(1)));

    // A slot index beyond the depth reads as empty.
    assign idx_in_range = ({1'b0, idx_reg} < (SLOT_W + 1)'(TABLE_DEPTH));
    assign rd_used      = idx_in_range && used_reg[idx_reg[AW-1:0]];

    // Result assembly; fields that mean nothing for a status stay zero.
    always_comb
    begin
        result_next        = '0;
        result_next.status = cmd.emit_status;
        case (cmd.emit_status)
            ST_INSERTED:
            begin
                result_next.placed_slot = SLOT_W'(pos_reg);
                result_next.probe_count = COUNT_W'(count_reg);
            end
            ST_FULL:
            begin
                result_next.probe_count = COUNT_W'(eff_size);
            end
            ST_READ:
            begin
                result_next.read_used = rd_used;
                result_next.read_key  = rd_used ? ram_rdata : '0;
            end
            default: ;
        endcase
    end

    // Result register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
